>>> rtl/core/palette_gradient_table_gen_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the palette gradient table generator
// Checks compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PALETTE_GRADIENT_TABLE_GEN_TOP_ASSERT_SVH
`define PALETTE_GRADIENT_TABLE_GEN_TOP_ASSERT_SVH
`ifndef SYNTH
// Plain clocked property, disabled in reset
`define PGTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication
`define PGTG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define PGTG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PGTG_ASSERT(lbl, prop, msg)
`define PGTG_ASSERT_IMP(lbl, ante, cons, msg)
`define PGTG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/pgtg_pkg.sv
// ----------------------------------------------------------------------------
// pgtg_pkg
// Shared types and constants of the palette gradient table generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pgtg_pkg;

  localparam int PALETTE_SLOTS_DEF = 8;

  localparam int COLOUR_W    = 15;
  localparam int CH_W        = 5;
  localparam int WEIGHT_W    = 6;
  localparam int ACCUM_W     = 11;
  localparam int REM_W       = 10;
  localparam int LINE_W      = 8;
  localparam int BASE_W      = 8;
  localparam int COUNT_W     = 4;
  localparam int ALPHA_W     = 6;
  localparam int ADDR_W      = 16;
  localparam int SLOT_IN_W   = 3;
  localparam int OPCODE_W    = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 15;

  localparam int BLEND_STEPS  = 6;
  localparam int BLEND_STEP_W = 3;

  localparam int WEIGHT_FULL   = 32;
  localparam int RAMP_STEP     = 32;
  localparam int RESTORE_LIMIT = 223;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_NEXT  = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_BASE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_COUNT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_TARGET = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_ALPHA  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_TOTAL   = 3'd4;

  typedef struct packed {
    logic [OPCODE_W-1:0]  opcode;
    logic [SLOT_IN_W-1:0] slot;
    logic [COLOUR_W-1:0]  source_colour;
  } pgtg_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   address_word;
    logic [COLOUR_W-1:0] colour_word;
    logic                is_restore;
    logic                last;
  } pgtg_out_t;

  typedef struct packed {
    logic                start;
    logic [WEIGHT_W-1:0] w1;
    logic [WEIGHT_W-1:0] w2;
  } pgtg_blend_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pgtg_blend_st_t;

endpackage

`default_nettype wire

>>> rtl/core/pgtg_ram.sv
// ----------------------------------------------------------------------------
// pgtg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pgtg_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/core/pgtg_blend_unit.sv
// ----------------------------------------------------------------------------
// pgtg_blend_unit
// Sequential RGB555 blend over one shared 5x6 multiplier, six steps.
// ----------------------------------------------------------------------------
`default_nettype none

module pgtg_blend_unit import pgtg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pgtg_blend_ctl_t       ctl,
  input  wire logic [COLOUR_W-1:0]   src_colour,
  input  wire logic [COLOUR_W-1:0]   tgt_colour,
  output pgtg_blend_st_t             st,
  output logic      [COLOUR_W-1:0]   colour
);

  logic [COLOUR_W-1:0]     src_r, tgt_r, colour_r;
  logic [WEIGHT_W-1:0]     w1_r, w2_r, part_r;
  logic [BLEND_STEP_W-1:0] step_r;
  logic                    busy_r, done_r;

  logic [1:0]               ch;
  logic [COLOUR_W-1:0]      field_src;
  logic [CH_W-1:0]          opa;
  logic [WEIGHT_W-1:0]      opb;
  logic [CH_W+WEIGHT_W-1:0] prod;
  logic [WEIGHT_W-1:0]      term, chan_sum;

  // even step: source * w1, odd step: target * w2
  always_comb begin
    ch        = step_r[2:1];
    field_src = step_r[0] ? tgt_r : src_r;
    opb       = step_r[0] ? w2_r : w1_r;
    unique case (ch)
      2'd0:    opa = field_src[CH_W-1:0];
      2'd1:    opa = field_src[2*CH_W-1:CH_W];
      2'd2:    opa = field_src[3*CH_W-1:2*CH_W];
      default: opa = '0;
    endcase
    prod     = opa * opb;
    term     = prod[CH_W+WEIGHT_W-1:CH_W];
    chan_sum = part_r + term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      // one-cycle done pulse after the final step
      done_r <= busy_r && !ctl.start && (step_r == BLEND_STEP_W'(BLEND_STEPS - 1));
      if (ctl.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        src_r  <= src_colour;
        tgt_r  <= tgt_colour;
        w1_r   <= ctl.w1;
        w2_r   <= ctl.w2;
      end else if (busy_r) begin
        if (!step_r[0]) begin
          part_r <= term;
        end else begin
          unique case (ch)
            2'd0:    colour_r[CH_W-1:0]        <= chan_sum[CH_W-1:0];
            2'd1:    colour_r[2*CH_W-1:CH_W]   <= chan_sum[CH_W-1:0];
            default: colour_r[3*CH_W-1:2*CH_W] <= chan_sum[CH_W-1:0];
          endcase
        end
        if (step_r == BLEND_STEP_W'(BLEND_STEPS - 1)) begin
          busy_r <= 1'b0;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign colour  = colour_r;

endmodule

`default_nettype wire

>>> rtl/core/palette_gradient_table_gen_top.sv
// ---------------------------------------------------------------------------
// palette_gradient_table_gen_top: palette gradient table generator
// Load/start are taken only while idle. A restore pair reads the store and is pushed;
// a gradient pair also passes the 6-step shared multiplier and the
// one-add-per-cycle ramp loop before it is pushed.
// Sync active-low reset: idle, table done, config at reset values; store undefined.
// ---------------------------------------------------------------------------
`default_nettype none

`include "palette_gradient_table_gen_top_assert.svh"

module palette_gradient_table_gen_top import pgtg_pkg::*; #(
  parameter int PALETTE_SLOTS = PALETTE_SLOTS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire pgtg_in_t               in_data,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output pgtg_out_t                   out_data,
  // configuration
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // slot index width, and count width (holds PALETTE_SLOTS itself)
  localparam int SLOT_W = (PALETTE_SLOTS > 1) ? $clog2(PALETTE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(PALETTE_SLOTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_RAMP, S_PUSH} state_t;
  typedef enum logic [1:0] {PH_DONE, PH_GRAD, PH_REST} phase_t;

  state_t state_r;
  phase_t phase_r;

  // configuration registers
  logic [BASE_W-1:0]   palette_base_r;
  logic [COUNT_W-1:0]  slot_count_r;
  logic [COLOUR_W-1:0] blend_target_r;
  logic [ALPHA_W-1:0]  blend_alpha_r;
  logic [LINE_W-1:0]   line_total_r;

  // ramp state
  logic [LINE_W-1:0]        line_index_r;
  logic signed [REM_W-1:0]  rem_r;
  logic [ACCUM_W-1:0]       weight_r;
  logic [SLOT_W-1:0]        slot_index_r;

  // pending pair, filled while the transaction is worked on
  logic [ADDR_W-1:0]   pend_addr_r;
  logic [COLOUR_W-1:0] pend_colour_r;
  logic                pend_rest_r;
  logic                pend_last_r;

  // output register parts the two channels
  pgtg_out_t out_data_r;
  logic      out_valid_r;

  logic [COLOUR_W-1:0] rd_data;
  logic [COLOUR_W-1:0] blend_colour;
  pgtg_blend_ctl_t     blend_ctl;
  pgtg_blend_st_t      blend_st;

  logic [CNT_W-1:0]  eff_n;
  logic              rest_follows;
  logic              accept, do_next, grad_over, slot_wrap, load_ok;
  logic              push_go;
  phase_t            ph_eff;
  logic [SLOT_W-1:0] slot_eff, slot_use;
  logic [ADDR_W-1:0] addr_calc;
  logic              grad_last, rest_last;
  logic [CNT_W-1:0]  use_inc, step_inc;
  logic [SLOT_W-1:0] slot_step_nxt;
  logic              slot_step_wrap;
  logic [LINE_W-1:0] line_index_nxt;
  logic [WEIGHT_W-1:0] w2_raw, w2, w1;

  always_comb begin
    // effective slot count, clamped to 1..PALETTE_SLOTS
    if (slot_count_r == '0) begin
      eff_n = CNT_W'(1);
    end else if (8'(slot_count_r) > 8'(PALETTE_SLOTS)) begin
      eff_n = CNT_W'(PALETTE_SLOTS);
    end else begin
      eff_n = CNT_W'(slot_count_r);
    end
    rest_follows = line_total_r < (8'(RESTORE_LIMIT) - 8'(eff_n));

    accept  = in_valid && (state_r == S_IDLE);
    do_next = accept && (in_data.opcode == OP_NEXT);
    load_ok = accept && (in_data.opcode == OP_LOAD) &&
              (8'(in_data.slot) < 8'(PALETTE_SLOTS));

    // gradient ran out of lines before this transaction: hand over first
    grad_over = (phase_r == PH_GRAD) && (line_index_r >= line_total_r);
    if (grad_over) begin
      ph_eff   = rest_follows ? PH_REST : PH_DONE;
      slot_eff = '0;
    end else begin
      ph_eff   = phase_r;
      slot_eff = slot_index_r;
    end
    slot_wrap = CNT_W'(slot_eff) >= eff_n;
    slot_use  = slot_wrap ? '0 : slot_eff;

    addr_calc = {palette_base_r + BASE_W'(slot_use), 8'h00};
    grad_last = ({1'b0, line_index_r} + 9'd1 == {1'b0, line_total_r}) && !rest_follows;
    use_inc   = CNT_W'(slot_use) + CNT_W'(1);
    rest_last = use_inc >= eff_n;

    // slot advance after a pair
    step_inc       = CNT_W'(slot_index_r) + CNT_W'(1);
    slot_step_wrap = step_inc >= eff_n;
    slot_step_nxt  = slot_step_wrap ? '0 : SLOT_W'(step_inc);
    line_index_nxt = line_index_r + 1'b1;

    // weights, w2 saturating at full scale
    w2_raw = weight_r[ACCUM_W-1:ACCUM_W-WEIGHT_W];
    w2     = (w2_raw > WEIGHT_W'(WEIGHT_FULL)) ? WEIGHT_W'(WEIGHT_FULL) : w2_raw;
    w1     = WEIGHT_W'(WEIGHT_FULL) - w2;

    blend_ctl.start = (state_r == S_READ) && !pend_rest_r;
    blend_ctl.w1    = w1;
    blend_ctl.w2    = w2;

    // output register free, or emptied at this edge
    push_go = (state_r == S_PUSH) && (!out_valid_r || !out_stall);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // source colour store
  pgtg_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (PALETTE_SLOTS),
    .AW    (SLOT_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (load_ok),
    .wr_addr (SLOT_W'(in_data.slot)),
    .wr_data (in_data.source_colour),
    .rd_en   (do_next),
    .rd_addr (slot_use),
    .rd_data (rd_data)
  );

  pgtg_blend_unit u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (blend_ctl),
    .src_colour (rd_data),
    .tgt_colour (blend_target_r),
    .st         (blend_st),
    .colour     (blend_colour)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      phase_r        <= PH_DONE;
      line_index_r   <= '0;
      rem_r          <= '0;
      weight_r       <= '0;
      slot_index_r   <= '0;
      out_valid_r    <= 1'b0;
      palette_base_r <= '0;
      slot_count_r   <= COUNT_W'(1);
      blend_target_r <= '0;
      blend_alpha_r  <= '0;
      line_total_r   <= LINE_W'(224);
    end else begin
      // register writes; to be made only while idle, which the block does not enforce (no interlock)
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_PALETTE_BASE: palette_base_r <= cfg_data[BASE_W-1:0];
          CFG_SLOT_COUNT:   slot_count_r   <= cfg_data[COUNT_W-1:0];
          CFG_BLEND_TARGET: blend_target_r <= cfg_data[COLOUR_W-1:0];
          CFG_BLEND_ALPHA:  blend_alpha_r  <= cfg_data[ALPHA_W-1:0];
          CFG_LINE_TOTAL:   line_total_r   <= cfg_data[LINE_W-1:0];
          default: ;
        endcase
      end

      // output register: set on push, cleared once taken
      if (push_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_data.opcode == OP_START)) begin
            line_index_r <= '0;
            rem_r        <= '0;
            weight_r     <= '0;
            slot_index_r <= '0;
            phase_r      <= PH_GRAD;
          end else if (do_next) begin
            priority if (ph_eff == PH_GRAD) begin
              phase_r      <= ph_eff;
              slot_index_r <= slot_use;
              pend_rest_r  <= 1'b0;
              pend_last_r  <= grad_last;
              pend_addr_r  <= addr_calc;
              state_r      <= S_READ;
            end else if ((ph_eff == PH_REST) && !slot_wrap) begin
              phase_r      <= ph_eff;
              slot_index_r <= slot_eff;
              pend_rest_r  <= 1'b1;
              pend_last_r  <= rest_last;
              pend_addr_r  <= addr_calc;
              state_r      <= S_READ;
            end else begin
              // nothing to emit: restore ran past the count, or table done
              phase_r      <= PH_DONE;
              slot_index_r <= slot_eff;
            end
          end
        end
        S_READ: begin
          if (pend_rest_r) begin
            pend_colour_r <= rd_data;
            slot_index_r  <= slot_step_nxt;
            if (slot_step_wrap) begin
              phase_r <= PH_DONE;
            end
            state_r <= S_PUSH;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (blend_st.done) begin
            pend_colour_r <= blend_colour;
            rem_r         <= rem_r - REM_W'(RAMP_STEP);
            state_r       <= S_RAMP;
          end
        end
        S_RAMP: begin
          // Bresenham step: one add of line_total per cycle while negative
          if (rem_r[REM_W-1]) begin
            rem_r    <= rem_r + $signed({2'b00, line_total_r});
            weight_r <= weight_r + ACCUM_W'(blend_alpha_r);
          end else begin
            line_index_r <= line_index_nxt;
            if (line_index_nxt >= line_total_r) begin
              slot_index_r <= '0;
              phase_r      <= rest_follows ? PH_REST : PH_DONE;
            end else begin
              slot_index_r <= slot_step_nxt;
            end
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (push_go) begin
            out_data_r.address_word <= pend_addr_r;
            out_data_r.colour_word  <= pend_colour_r;
            out_data_r.is_restore   <= pend_rest_r;
            out_data_r.last         <= pend_last_r;
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // blend result is only expected while waiting for it
  `PGTG_ASSERT_IMP(a_blend_done_in_mul, blend_st.done, state_r == S_MUL, "blend done outside wait")
  // the wait for the blend never stalls on an idle unit
  `PGTG_ASSERT_IMP(a_mul_unit_active, state_r == S_MUL, blend_st.busy || blend_st.done, "blend unit idle in wait")
  // a pending result is never overwritten
  `PGTG_ASSERT_NXT(a_push_holds, (state_r == S_PUSH) && out_valid_r && out_stall, state_r == S_PUSH, "push overran pending result")
  // remainder stays within one ramp step below zero
  `PGTG_ASSERT(a_rem_bound, rem_r >= -10'sd32, "ramp remainder out of range")

endmodule

`default_nettype wire
